FILE: design/gdod_pkg.sv
// Shared types, constants and table functions for the Gregorian date offset/difference block.
`default_nettype none

package gdod_pkg;

  localparam int DN_W   = 25;  // signed day number, wide enough for date plus offset
  localparam int R_W    = 22;  // remaining days while splitting a day number
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int OFF_W  = 22;
  localparam int DIFF_W = 23;
  localparam int PC_W   = 5;
  localparam int K_W    = 4;
  localparam int Q_W    = 8;   // year / 100
  localparam int S_W    = 15;  // year + 399
  localparam int IN_W   = 72;
  localparam int OUT_W  = 48;

  localparam logic [S_W-1:0]          YEAR_BIAS = 15'd399;
  localparam logic [DN_W-1:0]         YEAR_DAYS = 25'd365;
  localparam logic [DN_W-1:0]         ERA_DAYS  = 25'd146097;
  localparam logic signed [DN_W-1:0]  DN_ONE    = 25'sd1;
  localparam logic signed [DN_W-1:0]  DN_LAST   = 25'sd3652059;  // 31 Dec 9999
  localparam logic signed [DN_W-1:0]  DIFF_HI   = 25'sd4194303;
  localparam logic signed [DN_W-1:0]  DIFF_LO   = -25'sd4194304;
  localparam logic [DIFF_W-1:0]       DIFF_SAT_HI = 23'h3FFFFF;
  localparam logic [DIFF_W-1:0]       DIFF_SAT_LO = 23'h400000;
  localparam logic [MON_W-1:0]        MON_JAN = 4'd1;
  localparam logic [MON_W-1:0]        MON_FEB = 4'd2;
  localparam logic [MON_W-1:0]        MON_DEC = 4'd12;
  localparam logic [YEAR_W-1:0]       YEAR_ONE = 14'd1;

  // Microcode step addresses used as jump targets
  localparam logic [PC_W-1:0] STEP_MON  = 5'd24;
  localparam logic [PC_W-1:0] STEP_DONE = 5'd25;

  typedef enum logic [3:0] {
    OP_QS     = 4'd0,  // q <= (year + 399) / 100
    OP_ACCY   = 4'd1,  // acc <= days before the year
    OP_LEAPIN = 4'd2,  // leap flag of the input year
    OP_ACCM   = 4'd3,  // add month, day; store day number
    OP_RANGE  = 4'd4,  // difference, shifted day number, range check
    OP_CSUB   = 4'd5,  // conditional subtract of a period, add its years
    OP_LEAPY  = 4'd6,  // leap flag of the rebuilt year
    OP_MON    = 4'd7,  // one month of the month walk
    OP_DONE   = 4'd8   // load output word
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             sel;     // 0: first date, 1: second date
    logic [K_W-1:0]   kidx;    // period index for OP_CSUB
    logic [PC_W-1:0]  target;  // jump target
  } ctrl_t;

  typedef struct packed {
    logic branch;  // take the jump of the current step
    logic hold;    // repeat the current step
  } stat_t;

  // Input word, last field in the lowest bits
  typedef struct packed {
    logic [3:0]              pad;
    logic [YEAR_W-1:0]       other_year;
    logic [MON_W-1:0]        other_month;
    logic [DAY_W-1:0]        other_day;
    logic signed [OFF_W-1:0] offset;
    logic [YEAR_W-1:0]       year;
    logic [MON_W-1:0]        month;
    logic [DAY_W-1:0]        day;
  } in_word_t;

  // Output word, last field in the lowest bits
  typedef struct packed {
    logic                    pad;
    logic                    out_of_range;
    logic [DIFF_W-1:0]       day_difference;
    logic [YEAR_W-1:0]       shifted_year;
    logic [MON_W-1:0]        shifted_month;
    logic [DAY_W-1:0]        shifted_day;
  } out_word_t;

  // Floor division by 100 through the reciprocal 5243 / 2^19, exact below 25600 (8-bit quotient)
  function automatic logic [Q_W-1:0] div100(input logic [S_W-1:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'd5243;
    return p[26:19];
  endfunction

  // 4/100/400 rule, given the year and its quotient by 100
  function automatic logic leap_from(input logic [YEAR_W-1:0] y, input logic [Q_W-1:0] q);
    logic [S_W-1:0] back;
    back = S_W'(q) * S_W'(100);
    return (y[1:0] == 2'b00) && ((back != S_W'(y)) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [MON_W-1:0] clamp_month(input logic [MON_W-1:0] m);
    if (m < MON_JAN) return MON_JAN;
    if (m > MON_DEC) return MON_DEC;
    return m;
  endfunction

  function automatic logic [8:0] before_month(input logic [MON_W-1:0] m);
    case (m)
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic lp);
    case (m)
      4'd2:    return lp ? 5'd29 : 5'd28;
      4'd4:    return 5'd30;
      4'd6:    return 5'd30;
      4'd9:    return 5'd30;
      4'd11:   return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  // Periods peeled off in turn: 400-year eras in binary multiples, two century
  // steps, 4-year cycles in binary multiples, two plain-year steps
  function automatic logic [R_W-1:0] csub_k(input logic [K_W-1:0] k);
    case (k)
      4'd0:    return 22'd2337552;
      4'd1:    return 22'd1168776;
      4'd2:    return 22'd584388;
      4'd3:    return 22'd292194;
      4'd4:    return 22'd146097;
      4'd5:    return 22'd73048;
      4'd6:    return 22'd36524;
      4'd7:    return 22'd23376;
      4'd8:    return 22'd11688;
      4'd9:    return 22'd5844;
      4'd10:   return 22'd2922;
      4'd11:   return 22'd1461;
      4'd12:   return 22'd730;
      4'd13:   return 22'd365;
      default: return '1;
    endcase
  endfunction

  function automatic logic [YEAR_W-1:0] csub_w(input logic [K_W-1:0] k);
    case (k)
      4'd0:    return 14'd6400;
      4'd1:    return 14'd3200;
      4'd2:    return 14'd1600;
      4'd3:    return 14'd800;
      4'd4:    return 14'd400;
      4'd5:    return 14'd200;
      4'd6:    return 14'd100;
      4'd7:    return 14'd64;
      4'd8:    return 14'd32;
      4'd9:    return 14'd16;
      4'd10:   return 14'd8;
      4'd11:   return 14'd4;
      4'd12:   return 14'd2;
      4'd13:   return 14'd1;
      default: return 14'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: design/gregorian_date_offset_and_difference.sv
// Top level of the Gregorian date offset and day-difference block.
// Each input word runs the microcode from step 0 to the output load; an out-of-range shift
//   jumps from the range check straight to the load; the month walk repeats per whole month.
// Throughput: one word per run of the microcode; the next input is taken once the run ends,
//   and a waiting output word does not block the next input.
// Reset: synchronous active-high rst returns the sequencer to idle and drops m_axis_tvalid.
`default_nettype none

module gregorian_date_offset_and_difference (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // day[4:0], month[8:5], year[22:9], offset[44:23], other_day[49:45],
  // other_month[53:50], other_year[67:54], zero pad[71:68]
  input  wire logic [gdod_pkg::IN_W-1:0]   s_axis_tdata,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // shifted_day[4:0], shifted_month[8:5], shifted_year[22:9],
  // day_difference[45:23], out_of_range[46], zero pad[47]
  output logic [gdod_pkg::OUT_W-1:0]       m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready
);

  // The work runs as a short microprogram:
  //   steps 0-7   day numbers of both dates (divide-by-100 shared through one multiplier)
  //   step  8     saturated difference, first date plus offset, range check
  //   steps 9-22  peel 400/100/4/1-year periods off the shifted day number
  //   step  23    leap flag of the rebuilt year
  //   step  24    month walk, repeats while a whole month remains
  //   step  25    load the output register, waits there if it is still full

  logic                           in_take;
  logic                           in_ready;
  logic                           run;
  logic [gdod_pkg::PC_W-1:0]      pc;
  gdod_pkg::ctrl_t                cw;
  gdod_pkg::stat_t                stat;
  gdod_pkg::in_word_t             in_word;
  gdod_pkg::out_word_t            out_word;

  assign s_axis_tready = in_ready;
  assign in_take       = s_axis_tvalid && in_ready;
  assign in_word       = gdod_pkg::in_word_t'(s_axis_tdata);
  assign m_axis_tdata  = gdod_pkg::OUT_W'(out_word);

  gdod_ucode u_ucode (
    .pc (pc),
    .cw (cw)
  );

  gdod_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_take  (in_take),
    .cw       (cw),
    .stat     (stat),
    .pc       (pc),
    .run      (run),
    .in_ready (in_ready)
  );

  gdod_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_word   (in_word),
    .run       (run),
    .cw        (cw),
    .stat      (stat),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

FILE: design/gdod_ucode.sv
// Microcode ROM: one control word per step address.
`default_nettype none

module gdod_ucode (
  input  wire logic [gdod_pkg::PC_W-1:0] pc,
  output gdod_pkg::ctrl_t                cw
);

  function automatic gdod_pkg::ctrl_t mk(input gdod_pkg::op_t op, input logic sel,
                                         input logic [gdod_pkg::K_W-1:0] kidx,
                                         input logic [gdod_pkg::PC_W-1:0] target);
    gdod_pkg::ctrl_t c;
    c.op     = op;
    c.sel    = sel;
    c.kidx   = kidx;
    c.target = target;
    return c;
  endfunction

  always_comb begin
    case (pc)
      // day number of the first date
      5'd0:  cw = mk(gdod_pkg::OP_QS,     1'b0, 4'd0, '0);
      5'd1:  cw = mk(gdod_pkg::OP_ACCY,   1'b0, 4'd0, '0);
      5'd2:  cw = mk(gdod_pkg::OP_LEAPIN, 1'b0, 4'd0, '0);
      5'd3:  cw = mk(gdod_pkg::OP_ACCM,   1'b0, 4'd0, '0);
      // day number of the second date
      5'd4:  cw = mk(gdod_pkg::OP_QS,     1'b1, 4'd0, '0);
      5'd5:  cw = mk(gdod_pkg::OP_ACCY,   1'b1, 4'd0, '0);
      5'd6:  cw = mk(gdod_pkg::OP_LEAPIN, 1'b1, 4'd0, '0);
      5'd7:  cw = mk(gdod_pkg::OP_ACCM,   1'b1, 4'd0, '0);
      // difference and shift; out of range skips to the end
      5'd8:  cw = mk(gdod_pkg::OP_RANGE,  1'b0, 4'd0, gdod_pkg::STEP_DONE);
      // split back into years
      5'd9:  cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd0, '0);
      5'd10: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd1, '0);
      5'd11: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd2, '0);
      5'd12: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd3, '0);
      5'd13: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd4, '0);
      5'd14: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd5, '0);
      5'd15: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd6, '0);
      5'd16: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd7, '0);
      5'd17: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd8, '0);
      5'd18: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd9, '0);
      5'd19: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd10, '0);
      5'd20: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd11, '0);
      5'd21: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd12, '0);
      5'd22: cw = mk(gdod_pkg::OP_CSUB,   1'b0, 4'd13, '0);
      5'd23: cw = mk(gdod_pkg::OP_LEAPY,  1'b0, 4'd0, '0);
      // month walk loops on itself while a whole month remains
      5'd24: cw = mk(gdod_pkg::OP_MON,    1'b0, 4'd0, gdod_pkg::STEP_MON);
      5'd25: cw = mk(gdod_pkg::OP_DONE,   1'b0, 4'd0, '0);
      default: cw = mk(gdod_pkg::OP_DONE, 1'b0, 4'd0, '0);
    endcase
  end

endmodule

`default_nettype wire

FILE: design/gdod_seq.sv
// Sequencer: step counter, conditional jumps and the idle/run state.
`default_nettype none

module gdod_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_take,
  input  wire gdod_pkg::ctrl_t           cw,
  input  wire gdod_pkg::stat_t           stat,
  output logic [gdod_pkg::PC_W-1:0]      pc,
  output logic                           run,
  output logic                           in_ready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t state;

  assign run      = (state == ST_RUN);
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_RUN;
            pc    <= '0;
          end
        end
        ST_RUN: begin
          if (stat.hold) begin
            pc <= pc;
          end else if (cw.op == gdod_pkg::OP_DONE) begin
            state <= ST_IDLE;
          end else if (stat.branch) begin
            pc <= cw.target;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/gdod_dp.sv
// Datapath: input word, day-number arithmetic, split back to a date, output register.
`default_nettype none

module gdod_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_take,
  input  wire gdod_pkg::in_word_t   in_word,
  input  wire logic                 run,
  input  wire gdod_pkg::ctrl_t      cw,
  output gdod_pkg::stat_t           stat,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output gdod_pkg::out_word_t       out_word
);

  gdod_pkg::in_word_t                   iw;
  logic [gdod_pkg::Q_W-1:0]             q;
  logic [gdod_pkg::DN_W-1:0]            acc;
  logic                                 leap;
  logic signed [gdod_pkg::DN_W-1:0]     d1;
  logic signed [gdod_pkg::DN_W-1:0]     d2;
  logic [gdod_pkg::DIFF_W-1:0]          diff;
  logic [gdod_pkg::R_W-1:0]             r;
  logic [gdod_pkg::YEAR_W-1:0]          y;
  logic [gdod_pkg::MON_W-1:0]           m;
  logic                                 oor;

  logic [gdod_pkg::YEAR_W-1:0]          yy_sel;
  logic [gdod_pkg::MON_W-1:0]           mm_sel;
  logic [gdod_pkg::DAY_W-1:0]           dd_sel;
  logic [gdod_pkg::S_W-1:0]             s_sel;
  logic [gdod_pkg::S_W-1:0]             div_in;
  logic [gdod_pkg::Q_W-1:0]             q_div;
  logic                                 leap_now;
  logic [gdod_pkg::DN_W-1:0]            acc_y;
  logic signed [gdod_pkg::DN_W-1:0]     acc_m;
  logic signed [gdod_pkg::DN_W-1:0]     n;
  logic signed [gdod_pkg::DN_W-1:0]     n_m1;
  logic signed [gdod_pkg::DN_W-1:0]     dd;
  logic [gdod_pkg::DIFF_W-1:0]          diff_sat;
  logic                                 oor_now;
  logic [gdod_pkg::R_W-1:0]             kval;
  logic                                 ge;
  logic [gdod_pkg::R_W-1:0]             len;
  logic                                 more;
  logic                                 out_full;
  logic                                 adj;
  logic                                 done_go;

  always_comb begin
    yy_sel = cw.sel ? iw.other_year : iw.year;
    mm_sel = gdod_pkg::clamp_month(cw.sel ? iw.other_month : iw.month);
    dd_sel = cw.sel ? iw.other_day : iw.day;
    s_sel  = gdod_pkg::S_W'(yy_sel) + gdod_pkg::YEAR_BIAS;

    // one shared divide-by-100 for the bias year, the input year and the rebuilt year
    case (cw.op)
      gdod_pkg::OP_QS:     div_in = s_sel;
      gdod_pkg::OP_LEAPIN: div_in = gdod_pkg::S_W'(yy_sel);
      default:             div_in = gdod_pkg::S_W'(y);
    endcase
    q_div    = gdod_pkg::div100(div_in);
    leap_now = gdod_pkg::leap_from(div_in[gdod_pkg::YEAR_W-1:0], q_div);

    // s*365 + s/4 - s/100 + s/400
    acc_y = gdod_pkg::DN_W'(s_sel) * gdod_pkg::YEAR_DAYS
          + gdod_pkg::DN_W'(s_sel >> 2)
          - gdod_pkg::DN_W'(q)
          + gdod_pkg::DN_W'(q >> 2);
    adj   = leap && (mm_sel > gdod_pkg::MON_FEB);
    acc_m = acc + gdod_pkg::DN_W'(gdod_pkg::before_month(mm_sel)) + gdod_pkg::DN_W'(adj)
          + gdod_pkg::DN_W'(dd_sel) - gdod_pkg::ERA_DAYS;

    n       = d1 + gdod_pkg::DN_W'(iw.offset);
    n_m1    = n - gdod_pkg::DN_ONE;
    oor_now = (n < gdod_pkg::DN_ONE) || (n > gdod_pkg::DN_LAST);

    dd = d1 - d2;
    if (dd > gdod_pkg::DIFF_HI) begin
      diff_sat = gdod_pkg::DIFF_SAT_HI;
    end else if (dd < gdod_pkg::DIFF_LO) begin
      diff_sat = gdod_pkg::DIFF_SAT_LO;
    end else begin
      diff_sat = dd[gdod_pkg::DIFF_W-1:0];
    end

    kval = gdod_pkg::csub_k(cw.kidx);
    ge   = (r >= kval);

    len  = gdod_pkg::R_W'(gdod_pkg::month_len(m, leap));
    more = (r >= len) && (m != gdod_pkg::MON_DEC);

    out_full    = out_valid && !out_ready;
    stat.branch = run && (((cw.op == gdod_pkg::OP_RANGE) && oor_now) ||
                          ((cw.op == gdod_pkg::OP_MON) && more));
    stat.hold   = run && (cw.op == gdod_pkg::OP_DONE) && out_full;
    done_go     = run && (cw.op == gdod_pkg::OP_DONE) && !out_full;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      iw <= in_word;
    end
    if (run) begin
      case (cw.op)
        gdod_pkg::OP_QS:     q    <= q_div;
        gdod_pkg::OP_ACCY:   acc  <= acc_y;
        gdod_pkg::OP_LEAPIN: leap <= leap_now;
        gdod_pkg::OP_ACCM: begin
          if (cw.sel) begin
            d2 <= acc_m;
          end else begin
            d1 <= acc_m;
          end
        end
        gdod_pkg::OP_RANGE: begin
          diff <= diff_sat;
          oor  <= oor_now;
          r    <= n_m1[gdod_pkg::R_W-1:0];
          y    <= gdod_pkg::YEAR_ONE;
          m    <= gdod_pkg::MON_JAN;
        end
        gdod_pkg::OP_CSUB: begin
          if (ge) begin
            r <= r - kval;
            y <= y + gdod_pkg::csub_w(cw.kidx);
          end
        end
        gdod_pkg::OP_LEAPY: leap <= leap_now;
        gdod_pkg::OP_MON: begin
          if (more) begin
            r <= r - len;
            m <= m + 1'b1;
          end
        end
        gdod_pkg::OP_DONE: begin
          if (!out_full) begin
            out_word.pad            <= 1'b0;
            out_word.out_of_range   <= oor;
            out_word.day_difference <= diff;
            out_word.shifted_day    <= oor ? '0 : r[gdod_pkg::DAY_W-1:0] + 1'b1;
            out_word.shifted_month  <= oor ? '0 : m;
            out_word.shifted_year   <= oor ? '0 : y;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/gdod_chk.sv
// Port-level checker for the date block, bound to the top level.
`default_nettype none

module gdod_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic [gdod_pkg::IN_W-1:0]   s_axis_tdata,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic [gdod_pkg::OUT_W-1:0]  m_axis_tdata,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready
);

  // no output word straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // one word at a time: input closes once a word is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still open after accept");

  // out of range clears the date fields
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[46] |-> m_axis_tdata[22:0] == 23'd0)
    else $error("date fields not zero when out of range");

  // a date in range has a nonzero day, a month of 1 to 12 and a year of 1 to 9999
  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[46] |->
      m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[8:5] != 4'd0 && m_axis_tdata[8:5] <= 4'd12 &&
      m_axis_tdata[22:9] != 14'd0 && m_axis_tdata[22:9] <= 14'd9999)
    else $error("shifted date fields out of range");

endmodule

bind gregorian_date_offset_and_difference gdod_chk u_gdod_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

FILE: dv/date_result_checker.sv
// Watches both streams of the date block, predicts each result word and compares it.
module date_result_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [gdod_pkg::IN_W-1:0] s_axis_tdata,
  input  wire logic                      s_axis_tvalid,
  input  wire logic                      s_axis_tready,
  input  wire logic [gdod_pkg::OUT_W-1:0] m_axis_tdata,
  input  wire logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output int                             mismatch_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import gdod_pkg::*;

  localparam longint ERA_LEN  = 146097;
  localparam longint CENT_LEN = 36524;
  localparam longint QUAD_LEN = 1461;
  localparam longint YEAR_LEN = 365;
  localparam longint SPAN_MAX = 4194303;
  localparam longint SPAN_MIN = -4194304;

  out_word_t expected_dates[$];
  out_word_t want;
  out_word_t seen;
  int        fails   = 0;
  int        waiting = 0;

  assign mismatch_count = fails;
  assign pending        = waiting;

  function automatic logic leap_year(input longint y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic longint days_before(input int m);
    case (m)
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  function automatic longint days_in(input int m, input logic lp);
    case (m)
      2:       return lp ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Absolute day number, 1 Jan of year 1 is day 1; months outside 1..12 are clamped
  function automatic longint day_count(input logic [4:0] d, input logic [3:0] m,
                                       input logic [13:0] y);
    int     mm;
    longint s;
    longint n;
    mm = (m == 4'd0) ? 1 : (m > 4'd12) ? 12 : int'(m);
    s  = longint'(y) + 399;
    n  = s * 365 + s / 4 - s / 100 + s / 400 - ERA_LEN;
    n += days_before(mm);
    if (mm > 2 && leap_year(longint'(y))) n += 1;
    return n + longint'(d);
  endfunction

  function automatic out_word_t predict_shift_and_difference(input in_word_t w);
    longint    first_dn;
    longint    second_dn;
    longint    last_dn;
    longint    span;
    longint    off;
    longint    target;
    longint    rem;
    longint    eras;
    longint    cents;
    longint    quads;
    longint    yrs;
    longint    yr;
    longint    mlen;
    int        mon;
    logic      lp;
    out_word_t res;
    res       = '0;
    off       = longint'({{42{w.offset[OFF_W-1]}}, w.offset});
    first_dn  = day_count(w.day, w.month, w.year);
    second_dn = day_count(w.other_day, w.other_month, w.other_year);
    last_dn   = day_count(5'd31, 4'd12, 14'd9999);

    span = first_dn - second_dn;
    if (span > SPAN_MAX) span = SPAN_MAX;
    if (span < SPAN_MIN) span = SPAN_MIN;
    res.day_difference = span[DIFF_W-1:0];

    target = first_dn + off;
    if (target < 1 || target > last_dn) begin
      res.out_of_range = 1'b1;
    end else begin
      rem   = target - 1;
      eras  = rem / ERA_LEN;
      rem  -= eras * ERA_LEN;
      cents = rem / CENT_LEN;
      if (cents > 3) cents = 3;   // last day of a 400-year era
      rem  -= cents * CENT_LEN;
      quads = rem / QUAD_LEN;
      rem  -= quads * QUAD_LEN;
      yrs   = rem / YEAR_LEN;
      if (yrs > 3) yrs = 3;       // 31 Dec of a leap year
      rem  -= yrs * YEAR_LEN;
      yr    = eras * 400 + cents * 100 + quads * 4 + yrs + 1;
      lp    = leap_year(yr);
      mon   = 1;
      mlen  = days_in(mon, lp);
      while (!(rem < mlen || mon == 12)) begin
        rem -= mlen;
        mon++;
        mlen = days_in(mon, lp);
      end
      res.shifted_day   = DAY_W'(rem + 1);
      res.shifted_month = MON_W'(mon);
      res.shifted_year  = YEAR_W'(yr);
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_dates.push_back(predict_shift_and_difference(in_word_t'(s_axis_tdata)));
      if (m_axis_tvalid && m_axis_tready) begin
        seen = out_word_t'(m_axis_tdata);
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got 0x%0h", $time,
                   m_axis_tdata);
          fails++;
        end else begin
          want = expected_dates.pop_front();
          check_field("shifted_day",    want.shifted_day,    seen.shifted_day);
          check_field("shifted_month",  want.shifted_month,  seen.shifted_month);
          check_field("shifted_year",   want.shifted_year,   seen.shifted_year);
          check_field("day_difference", want.day_difference, seen.day_difference);
          check_field("out_of_range",   want.out_of_range,   seen.out_of_range);
        end
      end
      waiting = expected_dates.size();
    end
  end

endmodule

FILE: dv/tb_gregorian_date_offset_and_difference.sv
// Stimulus and verdict for the Gregorian date offset and day-difference block.
module tb_gregorian_date_offset_and_difference;
  timeunit 1ns;
  timeprecision 1ps;

  import gdod_pkg::*;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic [IN_W-1:0]      s_axis_tdata  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  int mismatch_count;
  int pending;

  // Idle rates in percent; changed between the three phases of the random run
  int tx_idle_pct = 38;
  int rx_idle_pct = 59;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gregorian_date_offset_and_difference DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  date_result_checker result_watch (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // Receiver back-pressure: redrawn every cycle at the falling edge
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Offer one input word; called and returns at a falling edge. tvalid is only
  // dropped for an idle gap, never lowered and raised in the same step.
  task automatic send_dates(input int d, input int m, input int y, input int off,
                            input int od, input int om, input int oy);
    in_word_t w;
    w             = '0;
    w.day         = d[DAY_W-1:0];
    w.month       = m[MON_W-1:0];
    w.year        = y[YEAR_W-1:0];
    w.offset      = off[OFF_W-1:0];
    w.other_day   = od[DAY_W-1:0];
    w.other_month = om[MON_W-1:0];
    w.other_year  = oy[YEAR_W-1:0];
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  <= w;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  function automatic int pick_year();
    case ($urandom_range(11))
      0:       return 1;
      1:       return 9999;
      2:       return 1600;
      3:       return 1900;
      4:       return 2000;
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(3))
      0:       return $urandom_range(800) - 400;
      1:       return $urandom_range(80000) - 40000;
      2:       return $urandom_range(1500000) - 750000;
      default: return int'($urandom_range(4194303)) - 2097152;
    endcase
  endfunction

  // Mostly well-formed dates with varied offsets; a share of raw noise covers
  // month codes above 12, day 0, years 0 and above 9999 and every field bit
  task automatic send_random_dates(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 82)
        send_dates($urandom_range(1, 31), $urandom_range(1, 12), pick_year(), pick_offset(),
                   $urandom_range(1, 31), $urandom_range(1, 12), pick_year());
      else
        send_dates($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                   int'($urandom_range(4194303)) - 2097152,
                   $urandom_range(31), $urandom_range(15), $urandom_range(16383));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: calendar corners and the special encodings
    send_dates( 1,  1,     1,        0,  1,  1,     1);  // earliest date
    send_dates(31, 12,  9999,        0,  1,  1,     1);  // latest date, widest in-range span
    send_dates(31, 12,  9999,        1,  1,  1,  9999);  // shifted past the end
    send_dates( 1,  1,     1,       -1,  1,  1,     1);  // shifted before the start
    send_dates(29,  2,  2000,        0,  1,  3,  2000);  // leap by the 400 rule
    send_dates(29,  2,  1900,        0, 28,  2,  1900);  // not leap by the 100 rule, rolls on
    send_dates(29,  2,  2024,      365, 29,  2,  2023);
    send_dates( 0,  3,  2023,        0,  0,  1,  2000);  // day zero is last of previous month
    send_dates(31,  2,  2023,      -59, 31,  4,  2023);  // excess day rolls forward
    send_dates(15,  0,  2020,       10, 15, 13,  2020);  // month below and above range
    send_dates(31, 15,  1999,        0,  1, 15,     1);
    send_dates( 1,  1,     0,      366, 31, 12,     0);  // year zero, leap
    send_dates(31, 15, 16383, -2097152,  1,  1,     0);  // difference saturates high
    send_dates( 1,  1,     0,  2097151, 31, 15, 16383);  // difference saturates low
    send_dates( 1,  1,     1,  2097151,  1,  1,     1);  // largest offset
    send_dates(31, 12,  9999, -2097152, 31, 12,  9999);  // smallest offset
    send_dates(31, 12,   400,        0, 31, 12,  2000);  // last day of a 400-year era
    send_dates(31, 12,     4,        0,  1,  1,     5);  // last day of a leap year
    send_dates( 1,  1, 10000,       -1,  1,  1, 10000);  // input year past 9999, back in range
    send_dates(31, 12,  9998,      365, 30, 12,  9999);
    send_dates(28,  2,  2100,        1,  1,  3,  2100);
    send_dates(31,  0,     0,    -1000, 31, 31, 16383);

    // Hold the sender until the block has drained completely
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);

    send_random_dates(170);

    tx_idle_pct = 59;
    rx_idle_pct = 38;
    send_random_dates(170);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_dates(160);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // Room for any stray word the block might still emit
    repeat (64) @(negedge clk);

    if (mismatch_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Run limit: several times the slowest legal run of about 530 words
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
